// ===== sv/tempo_map_time_converter_top_macros.svh =====
// Assertion macros for the tempo map time converter
`ifndef TEMPO_MAP_TIME_CONVERTER_TOP_MACROS_SVH
`define TEMPO_MAP_TIME_CONVERTER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset
`define TMTC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset
`define TMTC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== sv/tmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtc_pkg
// Shared types and constants of the tempo map time converter.
// ----------------------------------------------------------------------------
package tmtc_pkg;
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int TICK_W  = 32;
   localparam int TEMPO_W = 24;
   localparam int VAL_W   = 56;
   localparam int TPQ_W   = 15;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int SUM_W   = 64;
   localparam int DIV_W   = SUM_W + 32;
   localparam logic [VAL_W-1:0] Q56_MAX = {VAL_W{1'b1}};
   localparam logic [TPQ_W-1:0]   TPQ_RESET = 15'd480;
   localparam logic [TEMPO_W-1:0] FB_RESET  = 24'd500000;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0, CMD_APPEND = 2'd1, CMD_T2TIME = 2'd2, CMD_TIME2T = 2'd3
   } cmd_type;
   typedef enum logic [STAT_W-1:0] {
      ST_OK = 2'd0, ST_FULL = 2'd1, ST_ORDER = 2'd2, ST_SAT = 2'd3
   } status_type;
   localparam logic REG_TPQ = 1'b0;
   localparam logic REG_FB  = 1'b1;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  a;
      logic [31:0]       b;
      logic [31:0]       c;
   } div_req_type;
   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [SUM_W-1:0]  q;
   } div_rsp_type;
endpackage

// ===== sv/tmtc_if.sv =====
// ----------------------------------------------------------------------------
// tmtc_req_if / tmtc_rsp_if / tmtc_csr_if
// Valid/ready channels of the tempo map time converter.
// ----------------------------------------------------------------------------
interface tmtc_req_if;
   logic                         valid;
   logic                         ready;
   logic [tmtc_pkg::CMD_W-1:0]   command;
   logic [tmtc_pkg::TICK_W-1:0]  tick_value;
   logic [tmtc_pkg::TEMPO_W-1:0] tempo_us;
   logic [tmtc_pkg::VAL_W-1:0]   time_value;
   modport source (output valid, command, tick_value, tempo_us, time_value, input ready);
   modport sink (input valid, command, tick_value, tempo_us, time_value, output ready);
endinterface

interface tmtc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tmtc_pkg::VAL_W-1:0]   result_value;
   logic [tmtc_pkg::TEMPO_W-1:0] segment_tempo_us;
   logic [tmtc_pkg::STAT_W-1:0]  status;
   modport source (output valid, result_value, segment_tempo_us, status, input ready);
   modport sink (input valid, result_value, segment_tempo_us, status, output ready);
endinterface

interface tmtc_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/tmtc_div.sv =====
// ----------------------------------------------------------------------------
// tmtc_div
// Shared multiply/divide unit: floor(a*b / c). A shift-add multiply runs
// first, then a restoring divide takes one bit per cycle.
// ----------------------------------------------------------------------------
module tmtc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  tmtc_pkg::div_req_type     req,
   output tmtc_pkg::div_rsp_type     rsp
);
   import tmtc_pkg::*;

   logic [DIV_W-1:0] num_ff, num_in;
   logic [SUM_W-1:0] mcand_ff, mcand_in;
   logic [31:0]      mplier_ff, mplier_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic [SUM_W-1:0] q_ff, q_in;
   logic             ovf_ff, ovf_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             mul_ff, mul_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [32:0]      shifted;
   logic             ge;
   logic [DIV_W-1:0] addend;

   // one quotient bit per cycle, MSB first
   assign shifted = {rem_ff, num_ff[DIV_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   // multiplicand added when the current multiplier bit is set
   assign addend  = mplier_ff[31] ? {{(DIV_W-SUM_W){1'b0}}, mcand_ff} : '0;

   always_comb begin
      num_in    = num_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      q_in      = q_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;
      mul_in    = mul_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (req.start) begin
         num_in    = '0;
         mcand_in  = req.a;
         mplier_in = req.b;
         rem_in    = '0;
         den_in    = req.c;
         q_in      = '0;
         ovf_in    = 1'b0;
         cnt_in    = 7'd0;
         mul_in    = 1'b1;
         busy_in   = 1'b1;
      end else if (busy_ff && mul_ff) begin
         // shift-add multiply, multiplier MSB first
         num_in    = {num_ff[DIV_W-2:0], 1'b0} + addend;
         mplier_in = {mplier_ff[30:0], 1'b0};
         cnt_in    = cnt_ff + 7'd1;
         if (cnt_ff == 7'd31) begin
            mul_in = 1'b0;
            cnt_in = 7'd0;
         end
      end else if (busy_ff) begin
         rem_in = ge ? 32'(shifted - {1'b0, den_ff}) : shifted[31:0];
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         if (cnt_ff < 7'd32) begin
            ovf_in = ovf_ff | ge;
         end else begin
            q_in = {q_ff[SUM_W-2:0], ge};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd95) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff    <= num_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      mul_ff    <= mul_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      q_ff      <= q_in;
      ovf_ff    <= ovf_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.q    = q_ff;
endmodule

// ===== sv/tempo_map_time_converter_top.sv =====
// Clear and append do not use the divider. Tick to time walks every segment, then
// divides once on the shared unit (32 multiply + 96 divide steps); time to ticks
// divides once per segment boundary examined and once more at the end. One word in
// flight; the next word is accepted the cycle after the response is taken.
// Synchronous active-high reset empties the table and loads the default
// ticks per quarter (480) and fallback tempo (500000); table memory is not cleared.
// ----------------------------------------------------------------------------
// tempo_map_time_converter_top
// Tempo segment table with tick/time conversion over a shared divider.
// ----------------------------------------------------------------------------
`include "tempo_map_time_converter_top_macros.svh"
module tempo_map_time_converter_top #(
   parameter int MAX_SEGMENTS = tmtc_pkg::MAX_SEGMENTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tmtc_req_if.sink   req,
   tmtc_rsp_if.source rsp,
   tmtc_csr_if.sink   csr
);
   import tmtc_pkg::*;

   localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_EXEC  = 9'b000000010,
      S_RD    = 9'b000000100,
      S_ACC   = 9'b000001000,
      S_BDIV  = 9'b000010000,
      S_BWAIT = 9'b000100000,
      S_FDIV  = 9'b001000000,
      S_FWAIT = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   // table memories
   logic [TICK_W-1:0]  st_mem [MAX_SEGMENTS];
   logic [TEMPO_W-1:0] tp_mem [MAX_SEGMENTS];
   logic [TICK_W-1:0]  st_rd_ff, st_nx_ff, last_st_ff;
   logic [TEMPO_W-1:0] tp_rd_ff;
   logic [AW-1:0]      rd_addr;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff;
   logic [TPQ_W-1:0]   tpq_ff;
   logic [TEMPO_W-1:0] fb_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [TICK_W-1:0]  tick_ff;
   logic [TEMPO_W-1:0] tin_ff;
   logic [VAL_W-1:0]   tval_ff;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   bound_ff, bound_in;
   logic [TEMPO_W-1:0] rtempo_ff, rtempo_in;
   logic [TICK_W-1:0]  seg_st_ff, seg_st_in;
   logic [TICK_W-1:0]  span_ff, span_in;
   logic [TEMPO_W-1:0] sptp_ff, sptp_in;
   logic [VAL_W-1:0]   res_ff, res_in;
   logic [STAT_W-1:0]  stat_ff, stat_in;
   logic               wr_en;
   div_req_type        dreq;
   div_rsp_type        drsp;

   logic [CW-1:0]      n_eff;
   logic [TPQ_W-1:0]   tpq_eff;
   logic [TEMPO_W-1:0] fb_eff;
   logic               empty;
   logic [TICK_W-1:0]  cur_st, nxt_st, hi_val;
   logic [TEMPO_W-1:0] cur_tp;
   logic               has_next;
   logic [VAL_W:0]     fin_sum;
   logic [TICK_W-1:0]  hi_span;
   logic [TICK_W+TEMPO_W-1:0] acc_prod, span_prod;

   function automatic logic [VAL_W-1:0] tick_ff_ext(input logic [TICK_W-1:0] s);
      tick_ff_ext = {{(VAL_W-TICK_W-16){1'b0}}, s, 16'd0};
   endfunction

   assign empty   = (count_ff == '0);
   assign n_eff   = empty ? CW'(1) : count_ff;
   assign tpq_eff = (tpq_ff == '0) ? TPQ_W'(1) : tpq_ff;
   assign fb_eff  = (fb_ff == '0) ? TEMPO_W'(1) : fb_ff;
   assign cur_st  = empty ? '0 : st_rd_ff;
   assign cur_tp  = empty ? fb_eff : tp_rd_ff;
   assign nxt_st  = st_nx_ff;
   assign has_next = (idx_ff + CW'(1)) < n_eff;
   assign hi_val  = (has_next && nxt_st < tick_ff) ? nxt_st : tick_ff;

   // segment products, full width
   assign hi_span   = hi_val - cur_st;
   assign acc_prod  = hi_span * cur_tp;
   assign span_prod = span_ff * sptp_ff;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.result_value     = res_ff;
   assign rsp.segment_tempo_us = rtempo_ff;
   assign rsp.status           = stat_ff;

   // read address: current segment then its successor, one port each
   assign rd_addr = idx_ff[AW-1:0];
   assign wr_en   = (state_ff == S_EXEC) && (cmd_ff == CMD_APPEND) &&
                    (count_ff < CW'(MAX_SEGMENTS)) &&
                    (empty || tick_ff >= last_st_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         st_mem[count_ff[AW-1:0]] <= tick_ff;
         tp_mem[count_ff[AW-1:0]] <= (tin_ff == '0) ? TEMPO_W'(1) : tin_ff;
      end
      st_rd_ff <= st_mem[rd_addr];
      tp_rd_ff <= tp_mem[rd_addr];
      st_nx_ff <= st_mem[AW'(idx_ff + CW'(1))];
   end

   assign fin_sum = {1'b0, {tick_ff_ext(seg_st_ff)}} + {1'b0, drsp.q[VAL_W-1:0]};

   // sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      bound_in  = bound_ff;
      rtempo_in = rtempo_ff;
      seg_st_in = seg_st_ff;
      span_in   = span_ff;
      sptp_in   = sptp_ff;
      res_in    = res_ff;
      stat_in   = stat_ff;
      dreq      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in    = '0;
            rtempo_in = '0;
            stat_in   = ST_OK;
            idx_in    = '0;
            sum_in    = '0;
            bound_in  = '0;
            case (cmd_ff)
               CMD_CLEAR:  state_in = S_OUT;
               CMD_APPEND: begin
                  if (count_ff >= CW'(MAX_SEGMENTS)) begin
                     stat_in = ST_FULL;
                  end else if (!empty && tick_ff < last_st_ff) begin
                     stat_in = ST_ORDER;
                  end
                  state_in = S_OUT;
               end
               CMD_T2TIME: begin
                  rtempo_in = fb_eff;
                  state_in  = S_RD;
               end
               default: state_in = S_RD;
            endcase
         end
         S_RD: state_in = S_ACC;
         S_ACC: begin
            if (cmd_ff == CMD_T2TIME) begin
               if (hi_val > cur_st) begin
                  sum_in = sum_ff + SUM_W'(acc_prod);
               end
               if (cur_st <= tick_ff) begin
                  rtempo_in = cur_tp;
               end
               if (has_next) begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end else begin
                  state_in = S_FDIV;
               end
            end else begin
               seg_st_in = cur_st;
               rtempo_in = cur_tp;
               if (has_next) begin
                  span_in  = nxt_st - cur_st;
                  sptp_in  = cur_tp;
                  state_in = S_BDIV;
               end else begin
                  state_in = S_FDIV;
               end
            end
         end
         S_BDIV: begin
            sum_in      = sum_ff + SUM_W'(span_prod);
            dreq.start  = 1'b1;
            dreq.a      = sum_in;
            dreq.b      = 32'd65536;
            dreq.c      = 32'(tpq_eff);
            state_in    = S_BWAIT;
         end
         S_BWAIT: begin
            if (drsp.done) begin
               if (!drsp.ovf && {8'd0, tval_ff} <= drsp.q) begin
                  state_in = S_FDIV;
               end else if (drsp.ovf) begin
                  state_in = S_FDIV;
               end else begin
                  bound_in = drsp.q;
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_FDIV: begin
            dreq.start = 1'b1;
            if (cmd_ff == CMD_T2TIME) begin
               dreq.a = sum_ff;
               dreq.b = 32'd65536;
               dreq.c = 32'(tpq_eff);
            end else begin
               dreq.a = {8'd0, tval_ff} - bound_ff;
               dreq.b = 32'(tpq_eff);
               dreq.c = 32'(rtempo_ff);
            end
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (drsp.done) begin
               if (cmd_ff == CMD_T2TIME) begin
                  if (drsp.ovf || drsp.q[SUM_W-1:VAL_W] != '0) begin
                     res_in  = Q56_MAX;
                     stat_in = ST_SAT;
                  end else begin
                     res_in = drsp.q[VAL_W-1:0];
                  end
               end else begin
                  if (drsp.ovf || drsp.q[SUM_W-1:VAL_W] != '0 || fin_sum[VAL_W]) begin
                     res_in  = Q56_MAX;
                     stat_in = ST_SAT;
                  end else begin
                     res_in = fin_sum[VAL_W-1:0];
                  end
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         tpq_ff   <= TPQ_RESET;
         fb_ff    <= FB_RESET;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready) begin
            if (csr.index == REG_TPQ) begin
               tpq_ff <= csr.data[TPQ_W-1:0];
            end else begin
               fb_ff <= csr.data;
            end
         end
         if (state_ff == S_EXEC && cmd_ff == CMD_CLEAR) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + CW'(1);
         end
      end
      if (wr_en) begin
         last_st_ff <= tick_ff;
      end
      if (req.valid && req.ready) begin
         cmd_ff  <= req.command;
         tick_ff <= req.tick_value;
         tin_ff  <= req.tempo_us;
         tval_ff <= req.time_value;
      end
      idx_ff    <= idx_in;
      sum_ff    <= sum_in;
      bound_ff  <= bound_in;
      rtempo_ff <= rtempo_in;
      seg_st_ff <= seg_st_in;
      span_ff   <= span_in;
      sptp_ff   <= sptp_in;
      res_ff    <= res_in;
      stat_ff   <= stat_in;
   end

   tmtc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   `TMTC_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, count_ff <= CW'(MAX_SEGMENTS))
   `TMTC_ASSERT_IMP(a_busy_noready, clock, reset, state_ff != S_IDLE, !req.ready)
   `TMTC_ASSERT_NXT(a_clear_empties, clock, reset, state_ff == S_EXEC && cmd_ff == CMD_CLEAR, count_ff == '0)
   `TMTC_ASSERT_IMP(a_div_start_ctl, clock, reset, dreq.start, state_ff == S_BDIV || state_ff == S_FDIV)
endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tempo map time converter. A directed table is
// run first, then random phases of segment building and tick/time queries
// under several register settings. Each response word is checked against a
// cycle-free model of the table and its conversions, or a typed directed result.
// ----------------------------------------------------------------------------
module tb;
   import tmtc_pkg::*;

   localparam int NSEG     = MAX_SEGMENTS_DEF;
   localparam int WDOG_MAX = 40000;
   localparam int N_RANDOM = 1530;

   typedef struct {
      cmd_type               cmd;
      logic [TICK_W-1:0]     tick;
      logic [TEMPO_W-1:0]    tempo;
      logic [VAL_W-1:0]      tval;
   } word_type;

   typedef struct {
      logic [VAL_W-1:0]      value;
      logic [TEMPO_W-1:0]    tempo;
      status_type            status;
   } conv_type;

   typedef struct {
      word_type w;
      bit       typed;
      conv_type res;
   } row_type;

   logic clock;
   logic reset;
   tmtc_req_if req_if();
   tmtc_rsp_if rsp_if();
   tmtc_csr_if csr_if();

   tempo_map_time_converter_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // model state
   logic [TICK_W-1:0]  seg_tick [NSEG];
   logic [TEMPO_W-1:0] seg_tempo [NSEG];
   int                 seg_cnt;
   logic [TPQ_W-1:0]   tpq_reg;
   logic [TEMPO_W-1:0] fb_reg;

   conv_type conv_q[$];
   row_type  rows[$];
   int    n_fail;
   int    n_words;
   int    n_sat;
   int    n_full;
   int    n_order;
   bit    quiet;

   // floor(a*b/c) with quotient overflow above 64 bits
   function automatic logic [63:0] scale_div(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] c, output bit ovf);
      logic [127:0] p;
      logic [127:0] q;
      p = {64'd0, a} * {64'd0, b};
      q = p / {64'd0, c};
      ovf = |q[127:64];
      return q[63:0];
   endfunction

   // expected response of one word; updates the table
   function automatic conv_type convert(input word_type w);
      conv_type r;
      logic [63:0] tpq, sum, nxt, bound, frac, base;
      logic [TICK_W-1:0] s [NSEG];
      logic [TEMPO_W-1:0] t [NSEG];
      logic [TICK_W-1:0] hi;
      int n, i;
      bit o;
      r.value = '0;
      r.tempo = '0;
      r.status = ST_OK;
      tpq = (tpq_reg == 0) ? 64'd1 : 64'(tpq_reg);
      n = seg_cnt;
      if (n == 0) begin
         s[0] = '0;
         t[0] = (fb_reg == 0) ? 24'd1 : fb_reg;
         n = 1;
      end else begin
         for (i = 0; i < n; i++) begin
            s[i] = seg_tick[i];
            t[i] = seg_tempo[i];
         end
      end
      case (w.cmd)
         CMD_CLEAR: seg_cnt = 0;
         CMD_APPEND: begin
            if (seg_cnt >= NSEG) begin
               r.status = ST_FULL;
            end else if (seg_cnt > 0 && w.tick < seg_tick[seg_cnt-1]) begin
               r.status = ST_ORDER;
            end else begin
               seg_tick[seg_cnt] = w.tick;
               seg_tempo[seg_cnt] = (w.tempo == 0) ? 24'd1 : w.tempo;
               seg_cnt++;
            end
         end
         CMD_T2TIME: begin
            sum = 0;
            r.tempo = (fb_reg == 0) ? 24'd1 : fb_reg;
            for (i = 0; i < n; i++) begin
               hi = (i + 1 < n) ? s[i+1] : w.tick;
               if (hi > w.tick) hi = w.tick;
               if (hi > s[i]) sum += 64'(hi - s[i]) * 64'(t[i]);
               if (s[i] <= w.tick) r.tempo = t[i];
            end
            nxt = scale_div(sum, 64'd65536, tpq, o);
            if (o || nxt > 64'(Q56_MAX)) begin
               r.value = Q56_MAX;
               r.status = ST_SAT;
            end else begin
               r.value = nxt[VAL_W-1:0];
            end
         end
         default: begin
            sum = 0;
            bound = 0;
            for (i = 0; i + 1 < n; i++) begin
               sum += 64'(s[i+1] - s[i]) * 64'(t[i]);
               nxt = scale_div(sum, 64'd65536, tpq, o);
               if (o) nxt = '1;
               if (64'(w.tval) <= nxt) break;
               bound = nxt;
            end
            r.tempo = t[i];
            frac = scale_div(64'(w.tval) - bound, tpq, 64'(t[i]), o);
            base = 64'(s[i]) << 16;
            if (o || frac > 64'(Q56_MAX) - base) begin
               r.value = Q56_MAX;
               r.status = ST_SAT;
            end else begin
               r.value = VAL_W'(base + frac);
            end
         end
      endcase
      return r;
   endfunction

   // append one row to the directed table
   function automatic void add_row(input word_type w, input bit typed, input conv_type res);
      row_type rw;
      rw.w = w;
      rw.typed = typed;
      rw.res = res;
      rows = {rows, rw};
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // send one request word, with an optional gap in front
   task automatic send_word(input word_type w, input bit typed, input conv_type tv);
      conv_type r;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.command    = w.cmd;
      req_if.tick_value = w.tick;
      req_if.tempo_us   = w.tempo;
      req_if.time_value = w.tval;
      do @(posedge clock); while (!req_if.ready);
      r = convert(w);
      if (typed) r = tv;
      conv_q = {conv_q, r};
      if (r.status == ST_SAT) n_sat++;
      if (r.status == ST_FULL) n_full++;
      if (r.status == ST_ORDER) n_order++;
      n_words++;
      @(negedge clock);
   endtask

   // register write, only with the block drained
   task automatic write_reg(input logic idx, input logic [23:0] data);
      req_if.valid = 1'b0;
      wait (conv_q.size() == 0);
      repeat (20) @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == REG_TPQ) tpq_reg = data[TPQ_W-1:0];
      else fb_reg = data;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   function automatic word_type mk(input cmd_type c, input logic [31:0] tk,
                                   input logic [23:0] tp, input logic [55:0] tv);
      word_type w;
      w.cmd = c;
      w.tick = tk;
      w.tempo = tp;
      w.tval = tv;
      return w;
   endfunction

   function automatic logic [23:0] rand_tempo();
      case ($urandom_range(0, 5))
         0: return 24'd1;
         1: return '1;
         2: return 24'($urandom_range(0, 3));
         3: return 24'($urandom_range(100000, 1000000));
         default: return 24'($urandom);
      endcase
   endfunction

   // query tick near the table or anywhere
   function automatic logic [31:0] rand_tick();
      int k;
      if (seg_cnt > 0 && $urandom_range(0, 2) != 0) begin
         k = $urandom_range(0, seg_cnt - 1);
         return seg_tick[k] + 32'($urandom_range(0, 2000)) - 32'($urandom_range(0, 20));
      end
      if ($urandom_range(0, 1)) return 32'($urandom_range(0, 100000));
      return $urandom;
   endfunction

   // query time from a converted tick, small, or anywhere
   function automatic logic [55:0] rand_time();
      conv_type r;
      word_type w;
      int cnt_save;
      case ($urandom_range(0, 2))
         0: begin
            cnt_save = seg_cnt;
            w = mk(CMD_T2TIME, rand_tick(), '0, '0);
            r = convert(w);
            seg_cnt = cnt_save;
            return r.value + 56'($urandom_range(0, 4)) - 56'($urandom_range(0, 4));
         end
         1: return 56'($urandom_range(0, 1000000));
         default: return 56'({$urandom, $urandom});
      endcase
   endfunction

   // response stall bursts
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_if.ready = 1'b1;
         end else begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_if.ready = 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      conv_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (conv_q.size() == 0) begin
            $display("%0t: unexpected response value=%h tempo=%h status=%0d", $time,
                     rsp_if.result_value, rsp_if.segment_tempo_us, rsp_if.status);
            n_fail++;
         end else begin
            e = conv_q.pop_front();
            if (rsp_if.result_value !== e.value) begin
               $display("%0t: result_value expected %h actual %h", $time, e.value,
                        rsp_if.result_value);
               n_fail++;
            end
            if (rsp_if.segment_tempo_us !== e.tempo) begin
               $display("%0t: segment_tempo_us expected %h actual %h", $time, e.tempo,
                        rsp_if.segment_tempo_us);
               n_fail++;
            end
            if (rsp_if.status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status,
                        rsp_if.status);
               n_fail++;
            end
         end
      end
   end

   // watchdog on handshake silence
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready) || reset)
            idle = 0;
         else
            idle++;
         if (idle >= WDOG_MAX) begin
            $display("%0t: watchdog expired, %0d responses pending", $time, conv_q.size());
            $display("tempo_map_time_converter_top regression: fail");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      row_type rw;
      conv_type none;
      logic [23:0] cfg_tpq [6];
      logic [23:0] cfg_fb [6];
      int ph, k, nq, sent;
      logic [31:0] tk;

      reset = 1'b1;
      quiet = 1'b0;
      req_if.valid = 1'b0;
      req_if.command = CMD_CLEAR;
      req_if.tick_value = '0;
      req_if.tempo_us = '0;
      req_if.time_value = '0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_TPQ;
      csr_if.data = '0;
      n_fail = 0;
      n_words = 0;
      n_sat = 0;
      n_full = 0;
      n_order = 0;
      seg_cnt = 0;
      tpq_reg = TPQ_RESET;
      fb_reg = FB_RESET;
      for (int i = 0; i < NSEG; i++) begin
         seg_tick[i] = '0;
         seg_tempo[i] = '0;
      end
      none = '{value: '0, tempo: '0, status: ST_OK};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: typed results where obvious
      add_row(mk(CMD_T2TIME, 0, 0, 0), 1, '{0, 500000, ST_OK});
      add_row(mk(CMD_T2TIME, 480, 0, 0), 1, '{56'd32768000000, 500000, ST_OK});
      add_row(mk(CMD_TIME2T, 0, 0, 0), 1, '{0, 500000, ST_OK});
      add_row(mk(CMD_APPEND, 0, 0, 0), 1, none);
      add_row(mk(CMD_T2TIME, 480, 0, 0), 1, '{56'd65536, 1, ST_OK});
      add_row(mk(CMD_APPEND, 1000, '1, 0), 1, none);
      add_row(mk(CMD_APPEND, 999, 24'd7, 0), 1, '{0, 0, ST_ORDER});
      add_row(mk(CMD_APPEND, 1000, 24'd250000, 0), 1, none);
      add_row(mk(CMD_T2TIME, '1, 0, 0), 0, none);
      add_row(mk(CMD_T2TIME, 1000, 0, 0), 0, none);
      add_row(mk(CMD_TIME2T, 0, 0, '1), 0, none);
      add_row(mk(CMD_TIME2T, 0, 0, 56'h5555_5555_5555), 0, none);
      add_row(mk(CMD_TIME2T, '1, '1, 56'd65536000), 0, none);
      add_row(mk(CMD_CLEAR, '1, '1, '1), 1, none);
      add_row(mk(CMD_APPEND, 2000, 24'd600000, 0), 1, none);
      add_row(mk(CMD_T2TIME, 1500, 0, 0), 1, '{0, 500000, ST_OK});
      add_row(mk(CMD_T2TIME, 2480, 0, 0), 1, '{56'd39321600000, 600000, ST_OK});
      add_row(mk(CMD_TIME2T, 0, 0, 0), 1, '{56'd131072000, 600000, ST_OK});
      add_row(mk(CMD_TIME2T, 0, 0, '1), 0, none);
      add_row(mk(CMD_CLEAR, 0, 0, 0), 1, none);
      foreach (rows[i]) begin
         rw = rows[i];
         send_word(rw.w, rw.typed, rw.res);
      end

      // register settings per phase, extremes and zero among them
      cfg_tpq = '{480, 1, 32767, 0, 24'($urandom_range(1, 32767)), 24'h00FFFF};
      cfg_fb  = '{500000, 1, '1, 0, 24'($urandom), '1};
      sent = 0;
      for (ph = 0; ph < 6; ph++) begin
         write_reg(REG_TPQ, cfg_tpq[ph]);
         write_reg(REG_FB, cfg_fb[ph]);
         while (sent < (ph + 1) * (N_RANDOM / 6)) begin
            if (sent > N_RANDOM - 150) quiet = 1'b1;
            // one sequence: maybe clear, append segments, then queries
            if ($urandom_range(0, 3) != 0) begin
               send_word(mk(CMD_CLEAR, $urandom, 24'($urandom), 56'({$urandom, $urandom})),
                         0, none);
               sent++;
            end
            k = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 6);
            tk = (seg_cnt > 0) ? seg_tick[seg_cnt-1] : 32'($urandom_range(0, 3000));
            if ($urandom_range(0, 9) == 0) tk = $urandom;
            for (int j = 0; j < k; j++) begin
               if ($urandom_range(0, 9) == 0)
                  tk = tk - 32'($urandom_range(1, 500));
               else if ($urandom_range(0, 9) == 0)
                  tk = tk + $urandom;
               else
                  tk = tk + 32'($urandom_range(0, 3000));
               send_word(mk(CMD_APPEND, tk, rand_tempo(), 56'({$urandom, $urandom})),
                         0, none);
               sent++;
            end
            nq = (seg_cnt > 16) ? $urandom_range(1, 2) : $urandom_range(2, 8);
            for (int j = 0; j < nq; j++) begin
               if ($urandom_range(0, 1))
                  send_word(mk(CMD_T2TIME, rand_tick(), 24'($urandom),
                               56'({$urandom, $urandom})), 0, none);
               else
                  send_word(mk(CMD_TIME2T, $urandom, 24'($urandom), rand_time()), 0, none);
               sent++;
            end
         end
      end

      // drain
      @(negedge clock);
      req_if.valid = 1'b0;
      wait (conv_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d words over 6 register settings", n_words);
      $display("saturated %0d, table full %0d, out of order %0d", n_sat, n_full, n_order);
      if (n_fail == 0 && conv_q.size() == 0) begin
         $display("tempo_map_time_converter_top regression: pass");
      end else begin
         $display("tempo_map_time_converter_top regression: fail");
      end
      $finish;
   end
endmodule
